FILE: rtl/core/mexalu_pkg.sv
// Shared types and instruction codes for the execute stage ALU
`default_nettype none

package mexalu_pkg;

   // primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTIU = 6'h0b;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2b;

   // function codes for register type
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   // memory operation codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam logic [4:0]  LINK_REG         = 5'd31;
   localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;
   localparam logic [31:0] TEXT_BASE_RESET  = 32'h0040_0000;
   localparam logic [31:0] BRANCH_PC_OFFSET = 32'd4;
   localparam logic [31:0] LINK_PC_OFFSET   = 32'd8;

   typedef enum logic [3:0] {
      ALU_ZERO,
      ALU_ADD,
      ALU_SUB,
      ALU_AND,
      ALU_OR,
      ALU_NOR,
      ALU_SLTU,
      ALU_SLL,
      ALU_SRL,
      ALU_LUI,
      ALU_LINK
   } alu_op_type;

   typedef enum logic [1:0] {
      BSEL_RT,
      BSEL_SIMM,
      BSEL_ZIMM
   } b_sel_type;

   typedef enum logic [1:0] {
      DST_NONE,
      DST_RD,
      DST_RT,
      DST_LINK
   } dst_sel_type;

   typedef enum logic [2:0] {
      RDR_NONE,
      RDR_JR,
      RDR_BEQ,
      RDR_BNE,
      RDR_JUMP
   } redir_kind_type;

   typedef struct packed {
      alu_op_type     alu_op;
      b_sel_type      b_sel;
      dst_sel_type    dst_sel;
      redir_kind_type redir_kind;
      logic [1:0]     mem_op;
      logic           writes_reg;
      logic           recognized;
   } ctrl_type;

   typedef struct packed {
      logic [5:0]  opcode;
      logic [5:0]  funct;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
      logic [4:0]  rt_index;
      logic [4:0]  rd_index;
      logic [15:0] immediate;
      logic [4:0]  shift_amount;
      logic [31:0] inst_pc;
      logic [25:0] jump_index;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [4:0]  dest_reg;
      logic        writes_reg;
      logic [1:0]  mem_op;
      logic [31:0] store_data;
      logic        redirect;
      logic [31:0] redirect_target;
      logic        recognized;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/mexalu_decode.sv
// Opcode and function decode into execute controls
`default_nettype none

module mexalu_decode (
   input  wire logic [5:0]          opcode,
   input  wire logic [5:0]          funct,
   output mexalu_pkg::ctrl_type     ctrl
);
   import mexalu_pkg::*;

   always_comb begin
      ctrl            = '0;
      ctrl.recognized = 1'b1;
      unique case (opcode)
         OP_RTYPE: begin
            ctrl.writes_reg = 1'b1;
            ctrl.dst_sel    = DST_RD;
            unique case (funct)
               FN_ADDU: ctrl.alu_op = ALU_ADD;
               FN_SUBU: ctrl.alu_op = ALU_SUB;
               FN_AND:  ctrl.alu_op = ALU_AND;
               FN_OR:   ctrl.alu_op = ALU_OR;
               FN_NOR:  ctrl.alu_op = ALU_NOR;
               FN_SLTU: ctrl.alu_op = ALU_SLTU;
               FN_SLL:  ctrl.alu_op = ALU_SLL;
               FN_SRL:  ctrl.alu_op = ALU_SRL;
               FN_JR: begin
                  ctrl.writes_reg = 1'b0;
                  ctrl.dst_sel    = DST_NONE;
                  ctrl.redir_kind = RDR_JR;
               end
               default: begin
                  ctrl.writes_reg = 1'b0;
                  ctrl.dst_sel    = DST_NONE;
                  ctrl.recognized = 1'b0;
               end
            endcase
         end
         OP_ADDIU: begin
            ctrl.alu_op = ALU_ADD;  ctrl.b_sel = BSEL_SIMM;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
         end
         OP_ANDI: begin
            ctrl.alu_op = ALU_AND;  ctrl.b_sel = BSEL_ZIMM;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
         end
         OP_ORI: begin
            ctrl.alu_op = ALU_OR;   ctrl.b_sel = BSEL_ZIMM;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
         end
         OP_SLTIU: begin
            ctrl.alu_op = ALU_SLTU; ctrl.b_sel = BSEL_SIMM;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
         end
         OP_LUI: begin
            ctrl.alu_op = ALU_LUI;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
         end
         OP_LW: begin
            ctrl.alu_op = ALU_ADD;  ctrl.b_sel = BSEL_SIMM;
            ctrl.writes_reg = 1'b1; ctrl.dst_sel = DST_RT;
            ctrl.mem_op = MEM_LOAD;
         end
         OP_SW: begin
            ctrl.alu_op = ALU_ADD;  ctrl.b_sel = BSEL_SIMM;
            ctrl.mem_op = MEM_STORE;
         end
         OP_BEQ: ctrl.redir_kind = RDR_BEQ;
         OP_BNE: ctrl.redir_kind = RDR_BNE;
         OP_J:   ctrl.redir_kind = RDR_JUMP;
         OP_JAL: begin
            ctrl.redir_kind = RDR_JUMP;
            ctrl.alu_op     = ALU_LINK;
            ctrl.writes_reg = 1'b1;
            ctrl.dst_sel    = DST_LINK;
         end
         default: ctrl.recognized = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/mexalu_datapath.sv
// ALU, address and branch target datapath of the execute stage
`default_nettype none

module mexalu_datapath (
   input  wire mexalu_pkg::req_type  req,
   input  wire mexalu_pkg::ctrl_type ctrl,
   input  wire logic [31:0]          text_base,
   output mexalu_pkg::rsp_type       rsp
);
   import mexalu_pkg::*;

   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] operand_b;
   logic [31:0] branch_target;
   logic [31:0] jump_target;
   logic        operands_equal;

   assign simm           = {{16{req.immediate[15]}}, req.immediate};
   assign zimm           = {16'b0, req.immediate};
   assign operands_equal = (req.rs_value == req.rt_value);
   assign branch_target  = req.inst_pc + BRANCH_PC_OFFSET + {simm[29:0], 2'b00};
   assign jump_target    = (req.inst_pc & JUMP_REGION_MASK) + text_base
                           + {4'b0, req.jump_index, 2'b00};

   always_comb begin
      unique case (ctrl.b_sel)
         BSEL_RT:   operand_b = req.rt_value;
         BSEL_SIMM: operand_b = simm;
         BSEL_ZIMM: operand_b = zimm;
         default:   operand_b = req.rt_value;
      endcase
   end

   always_comb begin
      unique case (ctrl.alu_op)
         ALU_ADD:  rsp.result_value = req.rs_value + operand_b;
         ALU_SUB:  rsp.result_value = req.rs_value - operand_b;
         ALU_AND:  rsp.result_value = req.rs_value & operand_b;
         ALU_OR:   rsp.result_value = req.rs_value | operand_b;
         ALU_NOR:  rsp.result_value = ~(req.rs_value | operand_b);
         ALU_SLTU: rsp.result_value = {31'b0, (req.rs_value < operand_b)};
         ALU_SLL:  rsp.result_value = operand_b << req.shift_amount;
         ALU_SRL:  rsp.result_value = operand_b >> req.shift_amount;
         ALU_LUI:  rsp.result_value = {req.immediate, 16'b0};
         ALU_LINK: rsp.result_value = req.inst_pc + LINK_PC_OFFSET;
         default:  rsp.result_value = '0;
      endcase

      unique case (ctrl.dst_sel)
         DST_RD:   rsp.dest_reg = req.rd_index;
         DST_RT:   rsp.dest_reg = req.rt_index;
         DST_LINK: rsp.dest_reg = LINK_REG;
         default:  rsp.dest_reg = '0;
      endcase

      // not-taken branches leave the target at zero
      unique case (ctrl.redir_kind)
         RDR_JR: begin
            rsp.redirect        = 1'b1;
            rsp.redirect_target = req.rs_value;
         end
         RDR_BEQ: begin
            rsp.redirect        = operands_equal;
            rsp.redirect_target = operands_equal ? branch_target : '0;
         end
         RDR_BNE: begin
            rsp.redirect        = !operands_equal;
            rsp.redirect_target = operands_equal ? '0 : branch_target;
         end
         RDR_JUMP: begin
            rsp.redirect        = 1'b1;
            rsp.redirect_target = jump_target;
         end
         default: begin
            rsp.redirect        = 1'b0;
            rsp.redirect_target = '0;
         end
      endcase

      rsp.writes_reg = ctrl.writes_reg;
      rsp.mem_op     = ctrl.mem_op;
      rsp.store_data = (ctrl.mem_op == MEM_STORE) ? req.rt_value : '0;
      rsp.recognized = ctrl.recognized;
   end

endmodule

`default_nettype wire

FILE: rtl/core/mips_execute_stage_alu.sv
// Top level of the execute stage ALU: input register, decode, datapath, result register
`default_nettype none

// Execute stage for a MIPS-32 subset. Each accepted item is one decoded instruction
// with its operand values; it yields exactly one result item carrying the ALU value or
// memory address, destination register, write enable, memory operation, store data and
// any branch or jump redirect. An item passes the input register, then the result register,
// and a new item is taken every cycle as long as the result side keeps draining; when
// rsp_stall is held the block keeps one item in each register and then stalls the request
// side. csr_text_base_wdata is added to every J and JAL target; the user must write it only
// while no item is in flight, as the block itself does not enforce this.

module mips_execute_stage_alu (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_text_base_we,
   input  wire logic [31:0] csr_text_base_wdata,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_opcode,
   input  wire logic [5:0]  req_funct,
   input  wire logic [31:0] req_rs_value,
   input  wire logic [31:0] req_rt_value,
   input  wire logic [4:0]  req_rt_index,
   input  wire logic [4:0]  req_rd_index,
   input  wire logic [15:0] req_immediate,
   input  wire logic [4:0]  req_shift_amount,
   input  wire logic [31:0] req_inst_pc,
   input  wire logic [25:0] req_jump_index,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result_value,
   output logic [4:0]       rsp_dest_reg,
   output logic             rsp_writes_reg,
   output logic [1:0]       rsp_mem_op,
   output logic [31:0]      rsp_store_data,
   output logic             rsp_redirect,
   output logic [31:0]      rsp_redirect_target,
   output logic             rsp_recognized
);
   import mexalu_pkg::*;

   logic [31:0] text_base_ff, text_base_in;
   logic        in_valid_ff, in_valid_in;
   req_type     in_ff, in_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   req_type     req_bus;
   ctrl_type    ctrl;
   rsp_type     rsp_next;
   logic        out_free;
   logic        req_take;
   logic        in_advance;

   assign req_bus = '{opcode: req_opcode, funct: req_funct, rs_value: req_rs_value,
                      rt_value: req_rt_value, rt_index: req_rt_index,
                      rd_index: req_rd_index, immediate: req_immediate,
                      shift_amount: req_shift_amount, inst_pc: req_inst_pc,
                      jump_index: req_jump_index};

   // result register can load when empty or being drained this cycle
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign in_advance = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_take   = req_valid && !req_stall;

   mexalu_decode u_decode (
      .opcode (in_ff.opcode),
      .funct  (in_ff.funct),
      .ctrl   (ctrl)
   );

   mexalu_datapath u_datapath (
      .req       (in_ff),
      .ctrl      (ctrl),
      .text_base (text_base_ff),
      .rsp       (rsp_next)
   );

   always_comb begin
      text_base_in = csr_text_base_we ? csr_text_base_wdata : text_base_ff;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      in_in        = req_take ? req_bus : in_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      out_in       = in_advance ? rsp_next : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_base_ff <= TEXT_BASE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         text_base_ff <= text_base_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_value    = out_ff.result_value;
   assign rsp_dest_reg        = out_ff.dest_reg;
   assign rsp_writes_reg      = out_ff.writes_reg;
   assign rsp_mem_op          = out_ff.mem_op;
   assign rsp_store_data      = out_ff.store_data;
   assign rsp_redirect        = out_ff.redirect;
   assign rsp_redirect_target = out_ff.redirect_target;
   assign rsp_recognized      = out_ff.recognized;

endmodule

`default_nettype wire

FILE: rtl/core/mexalu_checker.sv
// Port-level checks for the execute stage ALU and their binding
`default_nettype none

module mexalu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result_value,
   input wire logic [4:0]  rsp_dest_reg,
   input wire logic        rsp_writes_reg,
   input wire logic [1:0]  rsp_mem_op,
   input wire logic [31:0] rsp_store_data,
   input wire logic        rsp_redirect,
   input wire logic [31:0] rsp_redirect_target,
   input wire logic        rsp_recognized
);
   import mexalu_pkg::*;

   // a stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_dest_reg) && $stable(rsp_writes_reg) && $stable(rsp_mem_op)
         && $stable(rsp_store_data) && $stable(rsp_redirect)
         && $stable(rsp_redirect_target) && $stable(rsp_recognized))
      else $error("result item changed while stalled");

   // unknown instructions have no side effects
   a_unknown_inert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_recognized |-> !rsp_writes_reg && !rsp_redirect
         && rsp_mem_op == MEM_NONE && rsp_result_value == '0 && rsp_store_data == '0)
      else $error("unrecognized item has side effects");

   // target, destination and store data are zero when unused
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_redirect || rsp_redirect_target == '0)
         && (rsp_writes_reg || rsp_dest_reg == '0)
         && (rsp_mem_op == MEM_STORE || rsp_store_data == '0))
      else $error("unused result field not zero");

   // a store never writes a register and a load always does
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_op != MEM_NONE |->
         (rsp_mem_op == MEM_LOAD && rsp_writes_reg && !rsp_redirect)
         || (rsp_mem_op == MEM_STORE && !rsp_writes_reg && !rsp_redirect))
      else $error("memory operation inconsistent with register write");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind mips_execute_stage_alu mexalu_checker u_mexalu_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the execute stage ALU: issues instructions, predicts and checks every result
`timescale 1ns / 1ps

module tb_top;
   import mexalu_pkg::*;

   localparam logic [5:0] UNKNOWN_OP = 6'h3f;
   localparam logic [5:0] UNKNOWN_FN = 6'h3f;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_text_base_we    = 1'b0;
   logic [31:0] csr_text_base_wdata = 32'h0;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_drv   = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_value;
   logic [4:0]  rsp_dest_reg;
   logic        rsp_writes_reg;
   logic [1:0]  rsp_mem_op;
   logic [31:0] rsp_store_data;
   logic        rsp_redirect;
   logic [31:0] rsp_redirect_target;
   logic        rsp_recognized;

   req_type     insns_to_issue[$];
   rsp_type     results_due[$];
   logic [31:0] text_base_now = TEXT_BASE_RESET;
   bit          req_taken = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned insns_queued = 0;
   int unsigned insns_taken = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count = 0;

   mips_execute_stage_alu i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_text_base_we    (csr_text_base_we),
      .csr_text_base_wdata (csr_text_base_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_drv.opcode),
      .req_funct           (req_drv.funct),
      .req_rs_value        (req_drv.rs_value),
      .req_rt_value        (req_drv.rt_value),
      .req_rt_index        (req_drv.rt_index),
      .req_rd_index        (req_drv.rd_index),
      .req_immediate       (req_drv.immediate),
      .req_shift_amount    (req_drv.shift_amount),
      .req_inst_pc         (req_drv.inst_pc),
      .req_jump_index      (req_drv.jump_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_dest_reg        (rsp_dest_reg),
      .rsp_writes_reg      (rsp_writes_reg),
      .rsp_mem_op          (rsp_mem_op),
      .rsp_store_data      (rsp_store_data),
      .rsp_redirect        (rsp_redirect),
      .rsp_redirect_target (rsp_redirect_target),
      .rsp_recognized      (rsp_recognized)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // expected outcome of one instruction for the given text base
   function automatic rsp_type execute_insn(req_type q, logic [31:0] base);
      rsp_type     r;
      logic [31:0] simm;
      logic [31:0] br_target;
      logic [31:0] jmp_target;
      r = '0;
      r.recognized = 1'b1;
      simm = {{16{q.immediate[15]}}, q.immediate};
      br_target = q.inst_pc + BRANCH_PC_OFFSET + (simm << 2);
      jmp_target = (q.inst_pc & JUMP_REGION_MASK) + base + {4'b0, q.jump_index, 2'b00};
      if (q.opcode == OP_RTYPE) begin
         r.writes_reg = 1'b1;
         r.dest_reg = q.rd_index;
         case (q.funct)
            FN_ADDU: r.result_value = q.rs_value + q.rt_value;
            FN_SUBU: r.result_value = q.rs_value - q.rt_value;
            FN_AND:  r.result_value = q.rs_value & q.rt_value;
            FN_OR:   r.result_value = q.rs_value | q.rt_value;
            FN_NOR:  r.result_value = ~(q.rs_value | q.rt_value);
            FN_SLTU: r.result_value = {31'b0, q.rs_value < q.rt_value};
            FN_SLL:  r.result_value = q.rt_value << q.shift_amount;
            FN_SRL:  r.result_value = q.rt_value >> q.shift_amount;
            FN_JR: begin
               r.writes_reg = 1'b0;
               r.dest_reg = '0;
               r.redirect = 1'b1;
               r.redirect_target = q.rs_value;
            end
            default: begin
               r.writes_reg = 1'b0;
               r.dest_reg = '0;
               r.recognized = 1'b0;
            end
         endcase
      end else begin
         case (q.opcode)
            OP_ADDIU: begin
               r.result_value = q.rs_value + simm;
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
            end
            OP_ANDI: begin
               r.result_value = q.rs_value & {16'h0, q.immediate};
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
            end
            OP_ORI: begin
               r.result_value = q.rs_value | {16'h0, q.immediate};
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
            end
            OP_SLTIU: begin
               r.result_value = {31'b0, q.rs_value < simm};
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
            end
            OP_LUI: begin
               r.result_value = {q.immediate, 16'h0};
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
            end
            OP_LW: begin
               r.result_value = q.rs_value + simm;
               r.writes_reg = 1'b1;
               r.dest_reg = q.rt_index;
               r.mem_op = MEM_LOAD;
            end
            OP_SW: begin
               r.result_value = q.rs_value + simm;
               r.mem_op = MEM_STORE;
               r.store_data = q.rt_value;
            end
            OP_BEQ: begin
               if (q.rs_value == q.rt_value) begin
                  r.redirect = 1'b1;
                  r.redirect_target = br_target;
               end
            end
            OP_BNE: begin
               if (q.rs_value != q.rt_value) begin
                  r.redirect = 1'b1;
                  r.redirect_target = br_target;
               end
            end
            OP_J: begin
               r.redirect = 1'b1;
               r.redirect_target = jmp_target;
            end
            OP_JAL: begin
               r.redirect = 1'b1;
               r.redirect_target = jmp_target;
               r.result_value = q.inst_pc + LINK_PC_OFFSET;
               r.writes_reg = 1'b1;
               r.dest_reg = LINK_REG;
            end
            default: r.recognized = 1'b0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] corner_imm();
      case ($urandom_range(0, 7))
         0: return 16'h0;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   function automatic req_type random_insn();
      req_type     q;
      int unsigned pick;
      q.opcode       = 6'($urandom_range(0, 63));
      q.funct        = 6'($urandom_range(0, 63));
      q.rs_value     = corner_word();
      q.rt_value     = corner_word();
      q.rt_index     = 5'($urandom_range(0, 31));
      q.rd_index     = 5'($urandom_range(0, 31));
      q.immediate    = corner_imm();
      q.shift_amount = 5'($urandom_range(0, 31));
      q.inst_pc      = corner_word();
      q.jump_index   = 26'($urandom_range(0, 26'h3ff_ffff));
      pick = $urandom_range(0, 99);
      // mostly supported codes, the rest left as raw noise
      if (pick < 45) begin
         q.opcode = OP_RTYPE;
         case ($urandom_range(0, 8))
            0: q.funct = FN_SLL;
            1: q.funct = FN_SRL;
            2: q.funct = FN_JR;
            3: q.funct = FN_ADDU;
            4: q.funct = FN_SUBU;
            5: q.funct = FN_AND;
            6: q.funct = FN_OR;
            7: q.funct = FN_NOR;
            default: q.funct = FN_SLTU;
         endcase
      end else if (pick < 90) begin
         case ($urandom_range(0, 10))
            0: q.opcode = OP_J;
            1: q.opcode = OP_JAL;
            2: q.opcode = OP_BEQ;
            3: q.opcode = OP_BNE;
            4: q.opcode = OP_ADDIU;
            5: q.opcode = OP_SLTIU;
            6: q.opcode = OP_ANDI;
            7: q.opcode = OP_ORI;
            8: q.opcode = OP_LUI;
            9: q.opcode = OP_LW;
            default: q.opcode = OP_SW;
         endcase
      end
      // equal operands so that branches and compares go both ways
      if ($urandom_range(0, 3) == 0 ||
          ((q.opcode == OP_BEQ || q.opcode == OP_BNE) && $urandom_range(0, 1) == 0)) begin
         q.rt_value = q.rs_value;
      end
      return q;
   endfunction

   function automatic req_type spec_insn(logic [5:0] op, logic [5:0] fn, logic [31:0] rs,
                                         logic [31:0] rt, logic [15:0] imm, logic [4:0] sh,
                                         logic [31:0] pc, logic [25:0] jidx);
      req_type q;
      q = random_insn();
      q.opcode = op;
      q.funct = fn;
      q.rs_value = rs;
      q.rt_value = rt;
      q.immediate = imm;
      q.shift_amount = sh;
      q.inst_pc = pc;
      q.jump_index = jidx;
      return q;
   endfunction

   task automatic add_insn(req_type q);
      insns_to_issue.push_back(q);
      insns_queued++;
   endtask

   task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 50) begin
         $display("mismatch at result %0d: %s got %h want %h", results_checked, field, got,
                  want);
      end
      mismatch_count++;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (insns_taken != insns_queued || results_due.size() != 0);
   endtask

   task automatic write_text_base(logic [31:0] value);
      repeat (3) @(negedge clock);
      csr_text_base_we <= 1'b1;
      csr_text_base_wdata <= value;
      @(negedge clock);
      csr_text_base_we <= 1'b0;
   endtask

   task automatic run_random(int unsigned count, int unsigned snd_pct, int unsigned rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      repeat (count) add_insn(random_insn());
      wait_drained();
   endtask

   // driver: holds a stalled item, otherwise takes the next one or idles
   always @(negedge clock) begin : drive
      req_type nxt;
      logic    nxt_valid;
      nxt = req_drv;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         nxt_valid = 1'b0;
         nxt = random_insn();
         if (insns_to_issue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = insns_to_issue.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_drv <= nxt;
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // monitor: checks results in order and predicts each accepted item
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               note_mismatch("result with no item pending", rsp_result_value, 32'h0);
            end else begin
               want = results_due.pop_front();
               if (rsp_result_value !== want.result_value)
                  note_mismatch("result_value", rsp_result_value, want.result_value);
               if (rsp_dest_reg !== want.dest_reg)
                  note_mismatch("dest_reg", 32'(rsp_dest_reg), 32'(want.dest_reg));
               if (rsp_writes_reg !== want.writes_reg)
                  note_mismatch("writes_reg", 32'(rsp_writes_reg), 32'(want.writes_reg));
               if (rsp_mem_op !== want.mem_op)
                  note_mismatch("mem_op", 32'(rsp_mem_op), 32'(want.mem_op));
               if (rsp_store_data !== want.store_data)
                  note_mismatch("store_data", rsp_store_data, want.store_data);
               if (rsp_redirect !== want.redirect)
                  note_mismatch("redirect", 32'(rsp_redirect), 32'(want.redirect));
               if (rsp_redirect_target !== want.redirect_target)
                  note_mismatch("redirect_target", rsp_redirect_target, want.redirect_target);
               if (rsp_recognized !== want.recognized)
                  note_mismatch("recognized", 32'(rsp_recognized), 32'(want.recognized));
            end
            results_checked++;
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            results_due.push_back(execute_insn(req_drv, text_base_now));
            insns_taken++;
         end
         if (csr_text_base_we) text_base_now = csr_text_base_wdata;
      end
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // directed: every operation, operand extremes, both branch outcomes, unknown codes
      send_idle_pct = 7;
      recv_idle_pct = 82;
      add_insn(spec_insn(OP_RTYPE, FN_ADDU, 32'hffff_ffff, 32'h1, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_SUBU, 32'h0, 32'h1, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_AND, 32'hffff_ffff, 32'ha5a5_5a5a, 16'h0, 5'd0, 32'h0,
                         26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_OR, 32'h0, 32'h0, 16'hffff, 5'd31, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_NOR, 32'h0, 32'h0, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_SLTU, 32'h0, 32'hffff_ffff, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_SLTU, 32'hffff_ffff, 32'h0, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_SLL, 32'h0, 32'hffff_ffff, 16'h0, 5'd31, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_SRL, 32'h0, 32'hffff_ffff, 16'h0, 5'd31, 32'h0, 26'h0));
      add_insn(spec_insn(OP_RTYPE, FN_JR, 32'hffff_ffff, 32'h0, 16'h0, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_ADDIU, FN_SLL, 32'h0, 32'h0, 16'h8000, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_ANDI, FN_SLL, 32'hffff_ffff, 32'h0, 16'hffff, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_ORI, FN_SLL, 32'h0, 32'h0, 16'h8000, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_SLTIU, FN_SLL, 32'hffff_fffe, 32'h0, 16'hffff, 5'd0, 32'h0,
                         26'h0));
      add_insn(spec_insn(OP_LUI, FN_SLL, 32'h0, 32'h0, 16'hffff, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_LW, FN_SLL, 32'h1, 32'h0, 16'hffff, 5'd0, 32'h0, 26'h0));
      add_insn(spec_insn(OP_SW, FN_SLL, 32'hffff_ffff, 32'hdead_beef, 16'h7fff, 5'd0, 32'h0,
                         26'h0));
      add_insn(spec_insn(OP_BEQ, FN_SLL, 32'h1234_5678, 32'h1234_5678, 16'h8000, 5'd0, 32'h0,
                         26'h0));
      add_insn(spec_insn(OP_BEQ, FN_SLL, 32'h0, 32'h1, 16'h0004, 5'd0, 32'h100, 26'h0));
      add_insn(spec_insn(OP_BNE, FN_SLL, 32'h0, 32'hffff_ffff, 16'h7fff, 5'd0, 32'hffff_fffc,
                         26'h0));
      add_insn(spec_insn(OP_BNE, FN_SLL, 32'h5, 32'h5, 16'h0010, 5'd0, 32'h400, 26'h0));
      add_insn(spec_insn(OP_J, FN_SLL, 32'h0, 32'h0, 16'h0, 5'd0, 32'hffff_ffff,
                         26'h3ff_ffff));
      add_insn(spec_insn(OP_JAL, FN_SLL, 32'h0, 32'h0, 16'h0, 5'd0, 32'hffff_fff8, 26'h0));
      add_insn(spec_insn(UNKNOWN_OP, UNKNOWN_FN, 32'hffff_ffff, 32'hffff_ffff, 16'hffff,
                         5'd31, 32'hffff_ffff, 26'h3ff_ffff));
      add_insn(spec_insn(OP_RTYPE, UNKNOWN_FN, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 5'd31,
                         32'hffff_ffff, 26'h3ff_ffff));
      wait_drained();

      write_text_base(32'h0);
      run_random(340, 7, 82);
      write_text_base(32'hffff_ffff);
      run_random(330, 82, 7);
      write_text_base($urandom);
      run_random(330, 0, 0);

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_500_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
